// ===== design/gsp_pkg.sv =====
// ----------------------------------------------------------------------------
// gsp_pkg: shared types and constants of the shortest path engine
// Vertex and row types, operation codes and the find-first-set result.
// ----------------------------------------------------------------------------
package gsp_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VERT_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = VERT_W + 1;

    typedef logic [VERT_W-1:0]       vert_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [MAX_VERTICES-1:0] row_t;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_REM   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    // Result of the lowest-set-bit search.
    typedef struct packed {
        logic  hit;
        vert_t idx;
    } ffs_t;

    function automatic row_t vert_onehot(input vert_t v);
        row_t r;
        r    = '0;
        r[v] = 1'b1;
        return r;
    endfunction

endpackage

// ===== design/gsp_ffs.sv =====
// ----------------------------------------------------------------------------
// gsp_ffs: lowest set bit finder
// Returns the index of the lowest set bit of a row and whether any is set.
// ----------------------------------------------------------------------------
module gsp_ffs (
    input  gsp_pkg::row_t vec,
    output gsp_pkg::ffs_t res
);

    always_comb
    begin
        res = '0;
        for (int i = gsp_pkg::MAX_VERTICES - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                res.hit = 1'b1;
                res.idx = gsp_pkg::VERT_W'(i);
            end
        end
    end

endmodule

// ===== design/graph_shortest_path_bfs.sv =====
// ----------------------------------------------------------------------------
// graph_shortest_path_bfs: unweighted shortest path engine
// Adjacency bit matrix with edge updates and breadth-first path queries.
// ----------------------------------------------------------------------------
// Edge add and remove read-modify-write both rows; clear and ignored items
// finish in IDLE. A query runs Q_POP, Q_ROW, Q_CAND, Q_SCAN per dequeued
// vertex and Q_SCAN again per enqueued one, then P_EMIT, P_WAIT per path
// vertex; the single adjacency read port and the lowest-bit finder set this.
// One item is in work at a time. Reset (rst_n, asynchronous, active low)
// empties the graph at once through per-row valid bits; count is 64.
module graph_shortest_path_bfs (
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration: active vertex count.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [6:0]            cfg_data,
    // Input channel.
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            opcode,
    input  gsp_pkg::vert_t        vertex_a,
    input  gsp_pkg::vert_t        vertex_b,
    // Result channel.
    output logic                  out_valid,
    input  logic                  out_stall,
    output gsp_pkg::vert_t        path_vertex,
    output logic                  found,
    output logic                  last
);

    typedef enum logic [3:0] {
        IDLE, E_WRA, E_WRB, Q_POP, Q_ROW, Q_CAND, Q_SCAN, RESP, P_EMIT, P_WAIT
    } state_t;

    state_t          state_reg;
    gsp_pkg::cnt_t   av_reg;
    gsp_pkg::vert_t  a_reg;
    gsp_pkg::vert_t  b_reg;
    logic            add_reg;
    gsp_pkg::vert_t  u_reg;
    gsp_pkg::vert_t  cur_reg;
    gsp_pkg::row_t   visited_reg;
    gsp_pkg::row_t   cand_reg;
    gsp_pkg::row_t   row_vld_reg;
    gsp_pkg::cnt_t   head_reg;
    gsp_pkg::cnt_t   tail_reg;
    gsp_pkg::vert_t  resp_vertex_reg;
    logic            resp_found_reg;
    logic            out_valid_reg;
    gsp_pkg::vert_t  path_vertex_reg;
    logic            found_reg;
    logic            last_reg;

    // Memories and their registered read data.
    gsp_pkg::row_t   adj_mem [gsp_pkg::MAX_VERTICES];
    gsp_pkg::vert_t  q_mem   [gsp_pkg::MAX_VERTICES];
    gsp_pkg::vert_t  par_mem [gsp_pkg::MAX_VERTICES];
    gsp_pkg::row_t   adj_rdata_reg;
    logic            adj_rvld_reg;
    gsp_pkg::vert_t  q_rdata_reg;
    gsp_pkg::vert_t  par_rdata_reg;

    logic            adj_we;
    gsp_pkg::vert_t  adj_waddr;
    gsp_pkg::row_t   adj_wdata;
    gsp_pkg::vert_t  adj_raddr;
    logic            q_we;
    gsp_pkg::vert_t  q_waddr;
    gsp_pkg::vert_t  q_wdata;
    logic            par_we;

    gsp_pkg::cnt_t   n_eff;
    gsp_pkg::row_t   nmask;
    gsp_pkg::row_t   adj_row;
    gsp_pkg::ffs_t   ffs;
    logic            in_acc;
    logic            out_free;
    logic            a_ok;
    logic            b_ok;

    assign cfg_ready   = 1'b1;
    assign in_stall    = (state_reg != IDLE);
    assign in_acc      = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign path_vertex = path_vertex_reg;
    assign found       = found_reg;
    assign last        = last_reg;
    assign out_free    = !out_valid_reg || !out_stall;

    // Counts above the matrix size saturate.
    assign n_eff = (av_reg > gsp_pkg::CNT_W'(gsp_pkg::MAX_VERTICES))
                 ? gsp_pkg::CNT_W'(gsp_pkg::MAX_VERTICES) : av_reg;
    assign a_ok  = {1'b0, vertex_a} < n_eff;
    assign b_ok  = {1'b0, vertex_b} < n_eff;

    always_comb
    begin
        for (int i = 0; i < gsp_pkg::MAX_VERTICES; i++)
        begin
            nmask[i] = gsp_pkg::CNT_W'(i) < n_eff;
        end
    end

    // A row never written since reset or the last clear reads as empty.
    assign adj_row = adj_rdata_reg & {gsp_pkg::MAX_VERTICES{adj_rvld_reg}};

    gsp_ffs u_ffs (
        .vec (cand_reg),
        .res (ffs)
    );

    // Memory port control. Edge updates rewrite row a, then row b; the
    // search reads the row of each vertex taken from the frontier queue.
    always_comb
    begin
        adj_we    = 1'b0;
        adj_waddr = a_reg;
        adj_wdata = add_reg ? (adj_row | gsp_pkg::vert_onehot(b_reg))
                            : (adj_row & ~gsp_pkg::vert_onehot(b_reg));
        adj_raddr = vertex_a;
        q_we      = 1'b0;
        q_waddr   = tail_reg[gsp_pkg::VERT_W-1:0];
        q_wdata   = ffs.idx;
        par_we    = 1'b0;
        case (state_reg)
            IDLE:
            begin
                q_waddr = '0;
                q_wdata = vertex_b;
                q_we    = in_acc && (opcode == gsp_pkg::OP_QUERY) && a_ok && b_ok
                          && (vertex_a != vertex_b);
            end
            E_WRA:
            begin
                adj_we    = 1'b1;
                adj_raddr = b_reg;
            end
            E_WRB:
            begin
                adj_we    = 1'b1;
                adj_waddr = b_reg;
                adj_wdata = add_reg ? (adj_row | gsp_pkg::vert_onehot(a_reg))
                                    : (adj_row & ~gsp_pkg::vert_onehot(a_reg));
            end
            Q_ROW:
            begin
                adj_raddr = q_rdata_reg;
            end
            Q_SCAN:
            begin
                par_we = ffs.hit;
                q_we   = ffs.hit && !tail_reg[gsp_pkg::VERT_W];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_mem[adj_waddr] <= adj_wdata;
        end
        adj_rdata_reg <= adj_mem[adj_raddr];
        adj_rvld_reg  <= row_vld_reg[adj_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[q_waddr] <= q_wdata;
        end
        q_rdata_reg <= q_mem[head_reg[gsp_pkg::VERT_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            par_mem[ffs.idx] <= u_reg;
        end
        par_rdata_reg <= par_mem[cur_reg];
    end

    // Sequencer: edge updates, breadth-first search from the destination,
    // then the walk along parent links from the source.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            av_reg        <= gsp_pkg::CNT_W'(gsp_pkg::MAX_VERTICES);
            row_vld_reg   <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                av_reg <= cfg_data;
            end
            if (adj_we)
            begin
                row_vld_reg[adj_waddr] <= 1'b1;
            end
            // The emitting states load the output register themselves.
            if (!out_stall && (state_reg != RESP) && (state_reg != P_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                IDLE:
                begin
                    if (in_acc)
                    begin
                        a_reg   <= vertex_a;
                        b_reg   <= vertex_b;
                        add_reg <= (opcode == gsp_pkg::OP_ADD);
                        case (opcode)
                            gsp_pkg::OP_CLEAR:
                            begin
                                row_vld_reg <= '0;
                            end
                            gsp_pkg::OP_QUERY:
                            begin
                                if (!a_ok || !b_ok)
                                begin
                                    resp_vertex_reg <= '0;
                                    resp_found_reg  <= 1'b0;
                                    state_reg       <= RESP;
                                end
                                else if (vertex_a == vertex_b)
                                begin
                                    resp_vertex_reg <= vertex_a;
                                    resp_found_reg  <= 1'b1;
                                    state_reg       <= RESP;
                                end
                                else
                                begin
                                    visited_reg <= gsp_pkg::vert_onehot(vertex_b);
                                    head_reg    <= '0;
                                    tail_reg    <= gsp_pkg::CNT_W'(1);
                                    state_reg   <= Q_POP;
                                end
                            end
                            default:
                            begin
                                if (a_ok && b_ok)
                                begin
                                    state_reg <= E_WRA;
                                end
                            end
                        endcase
                    end
                end
                E_WRA:
                begin
                    state_reg <= E_WRB;
                end
                E_WRB:
                begin
                    state_reg <= IDLE;
                end
                Q_POP:
                begin
                    if (head_reg < tail_reg)
                    begin
                        head_reg  <= head_reg + 1'b1;
                        state_reg <= Q_ROW;
                    end
                    else
                    begin
                        resp_vertex_reg <= '0;
                        resp_found_reg  <= 1'b0;
                        state_reg       <= RESP;
                    end
                end
                Q_ROW:
                begin
                    u_reg     <= q_rdata_reg;
                    state_reg <= Q_CAND;
                end
                Q_CAND:
                begin
                    cand_reg  <= adj_row & ~visited_reg & nmask;
                    state_reg <= Q_SCAN;
                end
                Q_SCAN:
                begin
                    if (!ffs.hit)
                    begin
                        state_reg <= Q_POP;
                    end
                    else
                    begin
                        visited_reg <= visited_reg | gsp_pkg::vert_onehot(ffs.idx);
                        cand_reg    <= cand_reg & ~gsp_pkg::vert_onehot(ffs.idx);
                        if (!tail_reg[gsp_pkg::VERT_W])
                        begin
                            tail_reg <= tail_reg + 1'b1;
                        end
                        if (ffs.idx == a_reg)
                        begin
                            cur_reg   <= a_reg;
                            state_reg <= P_EMIT;
                        end
                    end
                end
                RESP:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        path_vertex_reg <= resp_vertex_reg;
                        found_reg       <= resp_found_reg;
                        last_reg        <= 1'b1;
                        state_reg       <= IDLE;
                    end
                end
                P_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        path_vertex_reg <= cur_reg;
                        found_reg       <= 1'b1;
                        last_reg        <= (cur_reg == b_reg);
                        state_reg       <= (cur_reg == b_reg) ? IDLE : P_WAIT;
                    end
                end
                P_WAIT:
                begin
                    cur_reg   <= par_rdata_reg;
                    state_reg <= P_EMIT;
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the shortest path engine
// Drives edge updates, clears and path queries through the input channel,
// predicts every path result with a local breadth-first search over its own
// copy of the adjacency matrix, and checks the result channel field by field.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // One input transaction as queued for the driver.
    typedef struct {
        logic [1:0]     op;
        gsp_pkg::vert_t src;
        gsp_pkg::vert_t dst;
    } graph_cmd_t;

    // One result transaction as expected on the output channel.
    typedef struct {
        gsp_pkg::vert_t vertex;
        logic           found;
        logic           last;
    } path_step_t;

    localparam int CYCLE_LIMIT  = 1500000;
    localparam int SETTLE_TICKS = 20;
    localparam int HOLD_TICKS   = 500;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [6:0]     cfg_data = '0;
    logic           in_valid = 1'b0;
    logic           in_stall;
    logic [1:0]     opcode = gsp_pkg::OP_ADD;
    gsp_pkg::vert_t vertex_a = '0;
    gsp_pkg::vert_t vertex_b = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    gsp_pkg::vert_t path_vertex;
    logic           found;
    logic           last;

    graph_shortest_path_bfs dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .vertex_a    (vertex_a),
        .vertex_b    (vertex_b),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .path_vertex (path_vertex),
        .found       (found),
        .last        (last)
    );

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Commands waiting to be driven, and path steps waiting to be seen.
    graph_cmd_t pending_cmds[$];
    path_step_t expected_steps[$];

    // Local copy of the engine state: adjacency matrix and vertex count register.
    gsp_pkg::row_t model_rows [gsp_pkg::MAX_VERTICES];
    logic [6:0]    model_count = 7'd64;

    int error_count    = 0;
    int cycle_count    = 0;
    int sender_idle    = 0;
    int receiver_idle  = 0;
    bit hold_request   = 1'b0;
    int hold_left      = 0;
    bit cmd_taken      = 1'b0;

    initial
    begin
        for (int i = 0; i < gsp_pkg::MAX_VERTICES; i++)
        begin
            model_rows[i] = '0;
        end
    end

    // Every mismatch goes through here: one line, and the error count rises.
    task automatic report_mismatch(input string what, input int exp_val, input int got_val);
        error_count++;
        $display("[%0t] mismatch %s: expected %0d, got %0d", $realtime, what, exp_val, got_val);
    endtask

    // Appends one expected step at the end of the scoreboard queue.
    task automatic expect_step(input path_step_t step);
        expected_steps = {expected_steps, step};
    endtask

    // Breadth-first search from the destination, neighbours in ascending order,
    // stopping as soon as the source is reached. The parent links then lead
    // from the source back to the destination, which is the path to emit.
    task automatic predict_path(input gsp_pkg::vert_t src, input gsp_pkg::vert_t dst,
                                input int n);
        gsp_pkg::row_t  seen;
        gsp_pkg::vert_t parent [gsp_pkg::MAX_VERTICES];
        gsp_pkg::vert_t frontier [gsp_pkg::MAX_VERTICES];
        int             head;
        int             tail;
        bit             reached;
        int             u;
        int             steps;
        gsp_pkg::vert_t cur;
        path_step_t     step;
        seen     = gsp_pkg::vert_onehot(dst);
        head     = 0;
        tail     = 1;
        reached  = 1'b0;
        frontier[0] = dst;
        while (!reached && head < tail && head < gsp_pkg::MAX_VERTICES)
        begin
            u = frontier[head];
            head++;
            for (int v = 0; v < n && !reached; v++)
            begin
                if (model_rows[u][v] && !seen[v])
                begin
                    seen[v]   = 1'b1;
                    parent[v] = gsp_pkg::vert_t'(u);
                    if (tail < gsp_pkg::MAX_VERTICES)
                    begin
                        frontier[tail] = gsp_pkg::vert_t'(v);
                        tail++;
                    end
                    if (v == src)
                    begin
                        reached = 1'b1;
                    end
                end
            end
        end
        if (!reached)
        begin
            step = '{vertex: '0, found: 1'b0, last: 1'b1};
            expect_step(step);
            return;
        end
        cur   = src;
        steps = 0;
        while (1)
        begin
            step.vertex = cur;
            step.found  = 1'b1;
            step.last   = (cur == dst) || (steps == gsp_pkg::MAX_VERTICES - 1);
            expect_step(step);
            steps++;
            if (step.last)
            begin
                break;
            end
            cur = parent[cur];
        end
    endtask

    // Applies one accepted command to the local state and queues its results.
    task automatic predict_command(input logic [1:0] op, input gsp_pkg::vert_t a,
                                   input gsp_pkg::vert_t b);
        int         n;
        path_step_t step;
        n = (model_count > gsp_pkg::MAX_VERTICES) ? gsp_pkg::MAX_VERTICES
                                                  : int'(model_count);
        case (op)
            gsp_pkg::OP_CLEAR:
            begin
                for (int i = 0; i < gsp_pkg::MAX_VERTICES; i++)
                begin
                    model_rows[i] = '0;
                end
            end
            gsp_pkg::OP_ADD, gsp_pkg::OP_REM:
            begin
                // Edges touching an inactive vertex are dropped without effect.
                if (a < n && b < n)
                begin
                    model_rows[a][b] = (op == gsp_pkg::OP_ADD);
                    model_rows[b][a] = (op == gsp_pkg::OP_ADD);
                end
            end
            default:
            begin
                if (a >= n || b >= n)
                begin
                    step = '{vertex: '0, found: 1'b0, last: 1'b1};
                    expect_step(step);
                end
                else if (a == b)
                begin
                    step = '{vertex: a, found: 1'b1, last: 1'b1};
                    expect_step(step);
                end
                else
                begin
                    predict_path(a, b, n);
                end
            end
        endcase
    endtask

    // Input driver. A stalled transaction is held unchanged; otherwise the next
    // command goes out unless the sender idles this cycle. Exactly one
    // assignment to in_valid per falling edge.
    always @(negedge clk)
    begin
        if (rst_n && in_valid && !cmd_taken)
        begin
            in_valid <= 1'b1;
        end
        else if (rst_n && pending_cmds.size() > 0 && $urandom_range(0, 99) >= sender_idle)
        begin
            graph_cmd_t cmd;
            cmd = pending_cmds.pop_front();
            opcode   <= cmd.op;
            vertex_a <= cmd.src;
            vertex_b <= cmd.dst;
            in_valid <= 1'b1;
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // Receiver stall: forced high during a long hold-off, otherwise random.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < receiver_idle);
        end
    end

    // Hold-off counter. A request from the sequence starts a long stretch in
    // which the receiver refuses everything, so the engine backs up and stalls
    // its input while the sender keeps offering commands.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (hold_request)
        begin
            hold_left    <= HOLD_TICKS;
            hold_request <= 1'b0;
        end
    end

    // Monitor: predicts on every accepted input transaction and checks every
    // accepted output transaction against the oldest expected step. Signals
    // are read at the rising edge, before the design's updates land.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL graph_shortest_path_bfs");
            $finish;
        end
        cmd_taken = rst_n && in_valid && !in_stall;
        if (cmd_taken)
        begin
            predict_command(opcode, vertex_a, vertex_b);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_steps.size() == 0)
            begin
                report_mismatch("unexpected result, vertex", -1, path_vertex);
            end
            else
            begin
                path_step_t want;
                want = expected_steps.pop_front();
                if (path_vertex !== want.vertex)
                begin
                    report_mismatch("path_vertex", want.vertex, path_vertex);
                end
                if (found !== want.found)
                begin
                    report_mismatch("found", want.found, found);
                end
                if (last !== want.last)
                begin
                    report_mismatch("last", want.last, last);
                end
            end
        end
    end

    task automatic queue_cmd(input logic [1:0] op, input int a, input int b);
        graph_cmd_t cmd;
        cmd.op  = op;
        cmd.src = gsp_pkg::vert_t'(a);
        cmd.dst = gsp_pkg::vert_t'(b);
        pending_cmds = {pending_cmds, cmd};
    endtask

    // Mostly a vertex from the busy low range, now and then any 6-bit value.
    function automatic int pick_vertex(input int lim);
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom_range(0, gsp_pkg::MAX_VERTICES - 1);
        end
        return $urandom_range(0, lim - 1);
    endfunction

    // Random traffic weighted toward building a graph and querying it.
    task automatic queue_random(input int count, input int lim);
        int         r;
        logic [1:0] op;
        for (int i = 0; i < count; i++)
        begin
            r  = $urandom_range(0, 99);
            op = (r < 45) ? gsp_pkg::OP_ADD : (r < 55) ? gsp_pkg::OP_REM
               : (r < 58) ? gsp_pkg::OP_CLEAR : gsp_pkg::OP_QUERY;
            queue_cmd(op, pick_vertex(lim), pick_vertex(lim));
        end
    endtask

    // A simple chain 0-1-...-(len-1) built in shuffled order, then queried in
    // both directions, which gives the longest possible paths.
    task automatic queue_chain(input int len);
        int order[$];
        for (int i = 0; i < len - 1; i++)
        begin
            order = {order, i};
        end
        order.shuffle();
        queue_cmd(gsp_pkg::OP_CLEAR, 0, 0);
        foreach (order[i])
        begin
            queue_cmd(gsp_pkg::OP_ADD, order[i] + 1, order[i]);
        end
        queue_cmd(gsp_pkg::OP_QUERY, 0, len - 1);
        queue_cmd(gsp_pkg::OP_QUERY, len - 1, 0);
    endtask

    // Waits until every command went out and every expected step arrived,
    // then lets the engine finish any edge update still in flight.
    task automatic wait_until_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending_cmds.size() > 0 || in_valid || expected_steps.size() > 0);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    // Register write; only called while the engine is idle.
    task automatic write_vertex_count(input logic [6:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        model_count = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Phase 1: reset count of 64, no idling. Directed corners first.
        sender_idle   = 0;
        receiver_idle = 0;
        queue_cmd(gsp_pkg::OP_ADD, 0, 63);
        queue_cmd(gsp_pkg::OP_QUERY, 0, 63);
        queue_cmd(gsp_pkg::OP_QUERY, 63, 0);
        queue_cmd(gsp_pkg::OP_QUERY, 63, 63);     // source equals destination
        queue_cmd(gsp_pkg::OP_QUERY, 5, 6);       // no path at all
        queue_cmd(gsp_pkg::OP_ADD, 1, 1);         // self loop only sets the diagonal
        queue_cmd(gsp_pkg::OP_QUERY, 1, 2);
        queue_cmd(gsp_pkg::OP_ADD, 1, 2);
        queue_cmd(gsp_pkg::OP_ADD, 3, 2);
        queue_cmd(gsp_pkg::OP_ADD, 1, 4);
        queue_cmd(gsp_pkg::OP_ADD, 4, 3);
        queue_cmd(gsp_pkg::OP_QUERY, 1, 3);       // two equal-length routes, lowest index wins
        queue_cmd(gsp_pkg::OP_REM, 2, 3);
        queue_cmd(gsp_pkg::OP_QUERY, 1, 3);
        queue_cmd(gsp_pkg::OP_REM, 4, 3);
        queue_cmd(gsp_pkg::OP_QUERY, 3, 1);
        queue_cmd(gsp_pkg::OP_ADD, 42, 21);
        queue_cmd(gsp_pkg::OP_QUERY, 21, 42);
        queue_cmd(gsp_pkg::OP_CLEAR, 0, 0);
        queue_cmd(gsp_pkg::OP_QUERY, 0, 63);      // clear removed every edge
        queue_random(40, 12);
        queue_chain(gsp_pkg::MAX_VERTICES);
        wait_until_drained();

        // Phase 2: ten vertices, sender mostly idle. Out-of-range endpoints.
        write_vertex_count(7'd10);
        sender_idle = 85;
        queue_cmd(gsp_pkg::OP_ADD, 12, 3);        // ignored, endpoint inactive
        queue_cmd(gsp_pkg::OP_QUERY, 12, 3);      // invalid source
        queue_cmd(gsp_pkg::OP_QUERY, 3, 10);      // invalid destination
        queue_cmd(gsp_pkg::OP_ADD, 9, 0);
        queue_cmd(gsp_pkg::OP_QUERY, 0, 9);
        queue_random(60, 10);
        wait_until_drained();

        // Phase 3: counts of zero and one, receiver mostly stalling.
        sender_idle   = 0;
        receiver_idle = 85;
        write_vertex_count(7'd0);
        queue_cmd(gsp_pkg::OP_QUERY, 0, 0);       // nothing is valid, even equal ends fail
        queue_random(15, 1);
        wait_until_drained();
        write_vertex_count(7'd1);
        queue_cmd(gsp_pkg::OP_QUERY, 0, 0);
        queue_random(15, 1);
        wait_until_drained();

        // Phase 4: count above the maximum saturates; both sides idle a bit.
        write_vertex_count(7'd127);
        sender_idle   = 18;
        receiver_idle = 18;
        queue_random(30, 20);
        queue_chain(gsp_pkg::MAX_VERTICES);
        wait_until_drained();

        // Phase 5: forty vertices, long receiver hold-off while commands keep
        // arriving, then a pause of the sender until everything came out.
        write_vertex_count(7'd40);
        sender_idle   = 0;
        receiver_idle = 0;
        queue_random(30, 16);
        hold_request = 1'b1;
        queue_chain(40);
        wait_until_drained();
        queue_random(40, 16);
        wait_until_drained();

        // Phase 6: back to the full count with mixed idling.
        write_vertex_count(7'd64);
        sender_idle   = 18;
        receiver_idle = 18;
        queue_random(30, 24);
        wait_until_drained();

        if (expected_steps.size() != 0)
        begin
            report_mismatch("steps left over", 0, expected_steps.size());
        end
        if (error_count == 0)
        begin
            $display("PASS graph_shortest_path_bfs");
        end
        else
        begin
            $display("FAIL graph_shortest_path_bfs");
        end
        $finish;
    end

endmodule
